>>> rtl/assert_macros.svh
// Assertion helpers for the RTL; all are clocked on clk_i and
// disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_HOLDS(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/rsd_pkg.sv
package rsd_pkg;

  // APB address width: seven 32-bit registers at byte offsets 0..24
  localparam int unsigned PADDR_W = 5;

  // Ramp ends after this many ms, settle window in ms
  localparam logic [15:0] RAMP_END_MS = 16'd500;
  localparam logic [15:0] SETTLE_MS   = 16'd25;
  // From this time on the ramp value exceeds any 15-bit cruise limit
  localparam logic [15:0] RAMP_SAT_MS = 16'd640;

  // Gains in Q8.0 (signed 8-bit integers, no fraction bits)
  localparam logic signed [7:0] KP_Q8 = 8'sd67;
  localparam logic signed [7:0] KD_Q8 = 8'sd59;

  // Reciprocals: ceil(2^20/5), ceil(2^25/25), ceil(179*2^24/100)
  localparam logic [17:0] RAMP_RECIP  = 18'd209716;
  localparam logic [20:0] TAPER_RECIP = 21'd1342178;
  localparam logic [24:0] HEAD_RECIP  = 25'd30031217;

  // Heading correction large enough to saturate the right drive
  localparam logic signed [17:0] CORR_SAT = 18'sd131071;

  // Taper start value that turns the taper off
  localparam logic [23:0] DECEL_OFF = 24'hFFFFFF;

  typedef enum logic [2:0] {
    REG_CRUISE_LIM     = 3'd0,
    REG_TARGET_POS     = 3'd1,
    REG_SETTLE_BAND    = 3'd2,
    REG_FLOOR_SPEED    = 3'd3,
    REG_DECEL_START    = 3'd4,
    REG_TIMEOUT_MS     = 3'd5,
    REG_HEADING_TARGET = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [14:0]        cruise_lim;
    logic signed [23:0] target_position;
    logic [22:0]        settle_band;
    logic [14:0]        floor_speed;
    logic signed [23:0] decel_start;
    logic [15:0]        timeout_ms;
    logic signed [23:0] heading_target;
  } cfg_t;

  typedef struct packed {
    logic               first_sample;
    logic [15:0]        elapsed_ms;
    logic signed [23:0] left_position;
    logic signed [23:0] heading;
  } in_t;

  typedef struct packed {
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
    logic               finished;
  } out_t;

  // Products and flags passed from the front stage to the back stage
  typedef struct packed {
    logic               ramp_cruise;
    logic [14:0]        ramp_q;
    logic               taper_on;
    logic               taper_big;
    logic [15:0]        taper_q;
    logic signed [31:0] p_term;
    logic signed [31:0] d_term;
    logic signed [17:0] corr;
    logic               finished;
  } mid_t;

endpackage

>>> rtl/rsd_cfg.sv
module rsd_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rsd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output rsd_pkg::cfg_t              cfg_o
);

  rsd_pkg::cfg_t     cfg_q;
  rsd_pkg::reg_idx_e reg_idx;
  logic              wr_en;

  assign reg_idx = rsd_pkg::reg_idx_e'(paddr[rsd_pkg::PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Write registers on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cruise_lim      <= '0;
      cfg_q.target_position <= '0;
      cfg_q.settle_band     <= '0;
      cfg_q.floor_speed     <= '0;
      cfg_q.decel_start     <= rsd_pkg::DECEL_OFF;
      cfg_q.timeout_ms      <= '0;
      cfg_q.heading_target  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        rsd_pkg::REG_CRUISE_LIM:     cfg_q.cruise_lim      <= pwdata[14:0];
        rsd_pkg::REG_TARGET_POS:     cfg_q.target_position <= pwdata[23:0];
        rsd_pkg::REG_SETTLE_BAND:    cfg_q.settle_band     <= pwdata[22:0];
        rsd_pkg::REG_FLOOR_SPEED:    cfg_q.floor_speed     <= pwdata[14:0];
        rsd_pkg::REG_DECEL_START:    cfg_q.decel_start     <= pwdata[23:0];
        rsd_pkg::REG_TIMEOUT_MS:     cfg_q.timeout_ms      <= pwdata[15:0];
        rsd_pkg::REG_HEADING_TARGET: cfg_q.heading_target  <= pwdata[23:0];
        default: begin
        end
      endcase
    end
  end

  // Read back, signed registers sign-extended
  always_comb begin
    case (reg_idx)
      rsd_pkg::REG_CRUISE_LIM:     prdata = {17'd0, cfg_q.cruise_lim};
      rsd_pkg::REG_TARGET_POS:     prdata = {{8{cfg_q.target_position[23]}},
                                             cfg_q.target_position};
      rsd_pkg::REG_SETTLE_BAND:    prdata = {9'd0, cfg_q.settle_band};
      rsd_pkg::REG_FLOOR_SPEED:    prdata = {17'd0, cfg_q.floor_speed};
      rsd_pkg::REG_DECEL_START:    prdata = {{8{cfg_q.decel_start[23]}},
                                             cfg_q.decel_start};
      rsd_pkg::REG_TIMEOUT_MS:     prdata = {16'd0, cfg_q.timeout_ms};
      rsd_pkg::REG_HEADING_TARGET: prdata = {{8{cfg_q.heading_target[23]}},
                                             cfg_q.heading_target};
      default:                     prdata = '0;
    endcase
  end

endmodule

>>> rtl/rsd_front.sv
module rsd_front (
  input  rsd_pkg::in_t        in_i,
  input  rsd_pkg::cfg_t       cfg_i,
  input  logic signed [24:0]  err_hist_i,
  input  logic [15:0]         last_out_i,
  output rsd_pkg::mid_t       mid_o,
  output logic signed [24:0]  err_o,
  output logic [15:0]         last_out_o
);

  logic [15:0]        t;
  logic signed [24:0] err;
  logic signed [24:0] err_base;
  logic signed [25:0] derr;
  logic [24:0]        err_mag;
  logic               outside;
  logic [15:0]        last_base;
  logic [15:0]        last_next;
  logic [15:0]        settled;

  logic [17:0]        ramp_x;
  logic [35:0]        ramp_p;

  logic [23:0]        abs_pos;
  logic signed [25:0] over;
  logic [19:0]        taper_x;
  logic [40:0]        taper_p;

  logic signed [24:0] herr;
  logic               h_neg;
  logic [24:0]        h_mag;
  logic               h_sat;
  logic [15:0]        h_in;
  logic [40:0]        head_p;
  logic [16:0]        c_mag;
  logic signed [17:0] corr_val;

  assign t = in_i.elapsed_ms;

  // Position error and its change; a first sample starts with no history
  always_comb begin
    err      = {cfg_i.target_position[23], cfg_i.target_position}
             - {in_i.left_position[23], in_i.left_position};
    err_base = in_i.first_sample ? 25'sd0 : err_hist_i;
    derr     = {err[24], err} - {err_base[24], err_base};
    err_mag  = err[24] ? 25'(-err) : 25'(err);
  end

  // PD products
  assign mid_o.p_term = 32'(err) * rsd_pkg::KP_Q8;
  assign mid_o.d_term = 32'(derr) * rsd_pkg::KD_Q8;

  // Settle timing: remember the last time the error left the band
  always_comb begin
    outside   = err_mag > {2'b00, cfg_i.settle_band};
    last_base = in_i.first_sample ? 16'd0 : last_out_i;
    last_next = outside ? t : last_base;
    settled   = (t >= last_next) ? (t - last_next) : 16'd0;
  end

  assign mid_o.finished = (settled > rsd_pkg::SETTLE_MS) || (t >= cfg_i.timeout_ms);
  assign err_o      = err;
  assign last_out_o = last_next;

  // Ramp: floor(t*256/5) by reciprocal, exact below the saturation time
  assign mid_o.ramp_cruise = (t > rsd_pkg::RAMP_END_MS) || (t >= rsd_pkg::RAMP_SAT_MS);
  assign ramp_x      = {t[9:0], 8'd0};
  assign ramp_p      = 36'(ramp_x) * 36'(rsd_pkg::RAMP_RECIP);
  assign mid_o.ramp_q = ramp_p[34:20];

  // Taper: floor(d*128/25); distances of 8192 and up always hit the floor
  always_comb begin
    abs_pos = in_i.left_position[23] ? (~in_i.left_position + 24'd1)
                                     : in_i.left_position;
    over    = $signed({2'b00, abs_pos}) - 26'(cfg_i.decel_start);
    taper_x = {over[12:0], 7'd0};
  end

  assign mid_o.taper_on  = (cfg_i.decel_start != rsd_pkg::DECEL_OFF) && !over[25]
                           && (over != 26'sd0);
  assign mid_o.taper_big = over[25:13] != 13'd0;
  assign taper_p         = 41'(taper_x) * 41'(rsd_pkg::TAPER_RECIP);
  assign mid_o.taper_q   = taper_p[40:25];

  // Heading correction floor(179*herr/100) with dead zone
  always_comb begin
    herr  = {cfg_i.heading_target[23], cfg_i.heading_target}
          - {in_i.heading[23], in_i.heading};
    h_neg = herr[24];
    h_mag = h_neg ? 25'(-herr) : 25'(herr);
    h_sat = h_mag[24:16] != 9'd0;
    h_in  = (h_mag < 25'd100) ? 16'd0 : h_mag[15:0];
  end

  assign head_p = 41'(h_in) * 41'(rsd_pkg::HEAD_RECIP);

  // Negative errors round away from zero: add one when the product is inexact
  always_comb begin
    c_mag = head_p[40:24] + {16'd0, h_neg && (head_p[23:16] != 8'd0)};
    if (h_sat) begin
      corr_val = h_neg ? -rsd_pkg::CORR_SAT : rsd_pkg::CORR_SAT;
    end else begin
      corr_val = h_neg ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});
    end
  end

  assign mid_o.corr = corr_val;

endmodule

>>> rtl/rsd_back.sv
module rsd_back (
  input  rsd_pkg::mid_t  mid_i,
  input  rsd_pkg::cfg_t  cfg_i,
  output rsd_pkg::out_t  out_o
);

  logic [14:0]        ramp_lim;
  logic signed [16:0] taper_lim;
  logic signed [16:0] floor_ext;
  logic [14:0]        limit;
  logic signed [32:0] pd_sum;
  logic signed [32:0] lim_pos;
  logic signed [32:0] lim_neg;
  logic signed [32:0] left_sel;
  logic signed [15:0] left;
  logic signed [18:0] right_raw;
  logic signed [15:0] right_sat;

  // Drive limit: ramp or cruise; past the decel point the taper, clamped at the floor speed
  always_comb begin
    if (mid_i.ramp_cruise || (mid_i.ramp_q >= cfg_i.cruise_lim)) begin
      ramp_lim = cfg_i.cruise_lim;
    end else begin
      ramp_lim = mid_i.ramp_q;
    end
    taper_lim = $signed({2'b00, cfg_i.cruise_lim}) - $signed({1'b0, mid_i.taper_q});
    floor_ext = $signed({2'b00, cfg_i.floor_speed});
    if (!mid_i.taper_on) begin
      limit = ramp_lim;
    end else if (mid_i.taper_big || (taper_lim < floor_ext)) begin
      limit = cfg_i.floor_speed;
    end else begin
      limit = taper_lim[14:0];
    end
  end

  // Clamp the PD sum to the limit
  always_comb begin
    pd_sum  = 33'(mid_i.p_term) + 33'(mid_i.d_term);
    lim_pos = $signed({18'd0, limit});
    lim_neg = -lim_pos;
    if (pd_sum > lim_pos) begin
      left_sel = lim_pos;
    end else if (pd_sum < lim_neg) begin
      left_sel = lim_neg;
    end else begin
      left_sel = pd_sum;
    end
    left = left_sel[15:0];
  end

  // Right drive: subtract heading correction and saturate
  always_comb begin
    right_raw = 19'(left) - 19'(mid_i.corr);
    if (right_raw > 19'sd32767) begin
      right_sat = 16'sh7FFF;
    end else if (right_raw < -19'sd32768) begin
      right_sat = 16'sh8000;
    end else begin
      right_sat = right_raw[15:0];
    end
  end

  assign out_o.left_drive  = left;
  assign out_o.right_drive = right_sat;
  assign out_o.finished    = mid_i.finished;

endmodule

>>> rtl/ramped_straight_drive_pid.sv
// Throughput: one sample per cycle unless the output stalls; samples pass
// three registered stages (input, products, result) in that order, each with
// its own valid, so bubbles fill while the output stalls.
// Reset: pipeline valids, error history and settle time clear at once;
// configuration registers return to their reset values. No clearing pass.
`include "assert_macros.svh"

module ramped_straight_drive_pid (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rsd_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rsd_pkg::out_t               out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  rsd_pkg::cfg_t      cfg;
  rsd_pkg::in_t       in_q;
  rsd_pkg::mid_t      mid_d;
  rsd_pkg::mid_t      mid_q;
  rsd_pkg::out_t      out_d;
  rsd_pkg::out_t      out_q;
  logic               in_valid_q;
  logic               mid_valid_q;
  logic               out_valid_q;
  logic               in_stage_rdy;
  logic               mid_stage_rdy;
  logic               out_stage_rdy;
  logic               front_xfer;
  logic signed [24:0] err_hist_d;
  logic signed [24:0] err_hist_q;
  logic [15:0]        last_out_d;
  logic [15:0]        last_out_q;

  rsd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rsd_front u_front (
    .in_i       (in_q),
    .cfg_i      (cfg),
    .err_hist_i (err_hist_q),
    .last_out_i (last_out_q),
    .mid_o      (mid_d),
    .err_o      (err_hist_d),
    .last_out_o (last_out_d)
  );

  rsd_back u_back (
    .mid_i (mid_q),
    .cfg_i (cfg),
    .out_o (out_d)
  );

  // Per-stage ready: a stage advances when empty or when its successor takes it
  assign out_stage_rdy = !out_valid_q || out_ready_i;
  assign mid_stage_rdy = !mid_valid_q || out_stage_rdy;
  assign in_stage_rdy  = !in_valid_q || mid_stage_rdy;
  assign front_xfer    = in_valid_q && mid_stage_rdy;

  assign in_ready_o  = in_stage_rdy;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Valid bits and controller history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      err_hist_q  <= '0;
      last_out_q  <= '0;
    end else begin
      if (in_stage_rdy) begin
        in_valid_q <= in_valid_i;
      end
      if (mid_stage_rdy) begin
        mid_valid_q <= in_valid_q;
      end
      if (out_stage_rdy) begin
        out_valid_q <= mid_valid_q;
      end
      if (front_xfer) begin
        err_hist_q <= err_hist_d;
        last_out_q <= last_out_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_stage_rdy) begin
      in_q <= in_data_i;
    end
    if (front_xfer) begin
      mid_q <= mid_d;
    end
    if (mid_valid_q && out_stage_rdy) begin
      out_q <= out_d;
    end
  end

  `ASSERT_HOLDS(a_stall_full, !in_ready_o, in_valid_q && mid_valid_q && out_valid_q,
    "input stalled with a free pipeline stage")
  `ASSERT_NEXT(a_mid_hold, mid_valid_q && !out_stage_rdy, mid_valid_q,
    "product stage lost an item while the output stalled")
  `ASSERT_NEXT(a_mid_to_out, mid_valid_q && out_stage_rdy,
    out_valid_q && (out_q.finished == $past(mid_q.finished)),
    "product stage transfer did not reach the result register")
  `ASSERT_HOLDS(a_left_range, out_valid_q, out_q.left_drive != 16'sh8000,
    "left drive outside the symmetric limit range")

endmodule
